// File: hdl/psbf_pkg.sv
package psbf_pkg;

  localparam int unsigned Depth = 32;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned QDepth = 2;
  localparam logic [11:0] MinLen = 12'd20;
  localparam logic [1:0]  TypeCtrl = 2'h1;
  localparam logic [3:0]  SubBar = 4'h8;
  localparam logic [23:0] CountMax = 24'hFFFFFF;
  localparam logic [15:0] BucketMax = 16'hFFFF;
  localparam logic [47:0] BcastAddr = 48'hFFFF_FFFF_FFFF;
  localparam logic [9:0]  FloodRateRst = 10'd12;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_DROP  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_DROP  = 3'd0,
    KIND_UPD   = 3'd1,
    KIND_NEW   = 3'd2,
    KIND_EVICT = 3'd3,
    KIND_FLOOD = 3'd4,
    KIND_SUM   = 3'd5
  } kind_e;

  typedef struct packed {
    op_e         op;
    logic [47:0] xmit_addr;
    logic        bcast;
    logic [11:0] ssn;
    logic [3:0]  channel;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [47:0] addr;
    logic        bcast;
    logic [11:0] last_ssn;
    logic [10:0] max_jump;
    logic [3:0]  channel;
    logic [23:0] count;
    logic [15:0] bucket;
    logic [15:0] rate;
    logic [31:0] last_seen;
    logic [31:0] age_rank;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  slot;
    logic [47:0] xmit_addr;
    logic [23:0] frame_count;
    logic [15:0] rate_value;
    logic [10:0] ssn_max_jump;
    logic [3:0]  chan;
    logic        bcast_seen;
    logic [5:0]  flood_total;
    logic [5:0]  used_entries;
    logic        last_item;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0] used;
    logic [CntW-1:0] flags;
  } status_t;

endpackage

// File: hdl/psbf_front.sv
module psbf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  input  logic            pkt_is_ctrl_i,
  input  logic [11:0]     frame_len_i,
  input  logic [7:0]      frame_ctl0_i,
  input  logic [47:0]     recv_addr_i,
  input  logic [47:0]     xmit_addr_i,
  input  logic [15:0]     seq_ctrl_i,
  input  logic [3:0]      channel_i,
  input  logic [31:0]     now_ms_i,
  output logic            q_valid_o,
  output psbf_pkg::cmd_t  q_data_o,
  input  logic            q_pop_i
);
  import psbf_pkg::*;

  cmd_t       q_mem [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd;
  logic       push, keep;

  assign keep = pkt_is_ctrl_i && (frame_len_i >= MinLen) &&
                (frame_ctl0_i[3:2] == TypeCtrl) && (frame_ctl0_i[7:4] == SubBar);

  always_comb begin
    cmd.op        = func_i ? OP_TICK : (keep ? OP_FRAME : OP_DROP);
    cmd.xmit_addr = xmit_addr_i;
    cmd.bcast     = (recv_addr_i == BcastAddr);
    cmd.ssn       = seq_ctrl_i[15:4];
    cmd.channel   = channel_i;
    cmd.now_ms    = now_ms_i;
  end

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// File: hdl/psbf_back.sv
module psbf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [9:0]        flood_rate_i,
  input  logic              q_valid_i,
  input  psbf_pkg::cmd_t    q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output psbf_pkg::res_t    res_o,
  output psbf_pkg::status_t status_o
);
  import psbf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FSCAN = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FUPD  = 4'd3;
  localparam logic [3:0] S_DROP  = 4'd4;
  localparam logic [3:0] S_TSCAN = 4'd5;
  localparam logic [3:0] S_TCHK  = 4'd6;
  localparam logic [3:0] S_TOUT  = 4'd7;
  localparam logic [3:0] S_TSUM  = 4'd8;

  entry_t            mem [Depth];
  entry_t            rdata_q;
  logic [IdxW-1:0]   rd_addr;
  logic              we;
  logic [IdxW-1:0]   wa;
  entry_t            wd;

  logic [3:0]        state_q;
  cmd_t              cmd_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   e;
  logic [Depth-1:0]  valid_q, flag_q, rising_q;
  logic [CntW-1:0]   used_q, flags_q, fcnt_q;
  logic [31:0]       ins_seq_q;
  logic              hit_q, free_q;
  logic [IdxW-1:0]   hit_slot_q, free_slot_q, lru_slot_q, tgt_q, tgt_c;
  logic [31:0]       lru_seen_q, lru_age_q;
  logic              out_valid_q, out_free, full;
  res_t              res_q;
  entry_t            ne;
  logic [11:0]       jump;
  logic              now_flag;
  logic [CntW-1:0]   used_n, flags_n;

  assign e        = IdxW'(cnt_q - CntW'(1));
  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (used_q == CntW'(Depth));
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign tgt_c    = hit_q ? hit_slot_q : (full ? lru_slot_q : free_slot_q);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign status_o    = '{used: used_q, flags: flags_q};

  always_comb begin
    case (state_q)
      S_FSCAN, S_TSCAN, S_TCHK, S_TOUT: rd_addr = cnt_q[IdxW-1:0];
      S_FRD:                            rd_addr = tgt_c;
      S_FUPD:                           rd_addr = tgt_q;
      default:                          rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    ne       = rdata_q;
    jump     = cmd_q.ssn - rdata_q.last_ssn;
    now_flag = 1'b0;
    used_n   = used_q;
    flags_n  = flags_q;
    we       = 1'b0;
    wa       = e;
    wd       = rdata_q;
    if (state_q == S_FUPD) begin
      wa = tgt_q;
      if (hit_q) begin
        if (jump != 12'd0 && !jump[11] && jump[10:0] > rdata_q.max_jump)
          ne.max_jump = jump[10:0];
        ne.last_ssn  = cmd_q.ssn;
        ne.bcast     = rdata_q.bcast || cmd_q.bcast;
        ne.channel   = cmd_q.channel;
        ne.last_seen = cmd_q.now_ms;
        if (rdata_q.count < CountMax) ne.count = rdata_q.count + 24'd1;
        if (rdata_q.bucket < BucketMax) ne.bucket = rdata_q.bucket + 16'd1;
      end else begin
        ne.addr      = cmd_q.xmit_addr;
        ne.bcast     = cmd_q.bcast;
        ne.last_ssn  = cmd_q.ssn;
        ne.max_jump  = '0;
        ne.channel   = cmd_q.channel;
        ne.count     = 24'd1;
        ne.bucket    = 16'd1;
        ne.rate      = '0;
        ne.last_seen = cmd_q.now_ms;
        ne.age_rank  = ins_seq_q;
        if (full) flags_n = flags_q - CntW'(flag_q[tgt_q]);
        else      used_n  = used_q + CntW'(1);
      end
      we = out_free;
      wd = ne;
    end else if (state_q == S_TSCAN && cnt_q != '0) begin
      ne.rate   = rdata_q.bucket;
      ne.bucket = '0;
      now_flag  = (rdata_q.bucket >= {6'd0, flood_rate_i}) ||
                  (rdata_q.bcast && rdata_q.bucket >= {7'd0, flood_rate_i[9:1]});
      we = valid_q[e];
      wd = ne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      flag_q      <= '0;
      rising_q    <= '0;
      used_q      <= '0;
      flags_q     <= '0;
      fcnt_q      <= '0;
      ins_seq_q   <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_slot_q  <= '0;
      free_slot_q <= '0;
      lru_slot_q  <= '0;
      tgt_q       <= '0;
      lru_seen_q  <= '0;
      lru_age_q   <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          cnt_q  <= '0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
          fcnt_q <= '0;
          if (q_valid_i) begin
            cmd_q <= q_data_i;
            case (q_data_i.op)
              OP_FRAME: state_q <= S_FSCAN;
              OP_TICK:  state_q <= S_TSCAN;
              default:  state_q <= S_DROP;
            endcase
          end
        end
        S_FSCAN: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q != '0) begin
            if (valid_q[e] && rdata_q.addr == cmd_q.xmit_addr && !hit_q) begin
              hit_q      <= 1'b1;
              hit_slot_q <= e;
            end
            if (!valid_q[e] && !free_q) begin
              free_q      <= 1'b1;
              free_slot_q <= e;
            end
            if (e == '0 || rdata_q.last_seen < lru_seen_q ||
                (rdata_q.last_seen == lru_seen_q && rdata_q.age_rank < lru_age_q)) begin
              lru_slot_q <= e;
              lru_seen_q <= rdata_q.last_seen;
              lru_age_q  <= rdata_q.age_rank;
            end
          end
          if (cnt_q == CntW'(Depth)) state_q <= S_FRD;
        end
        S_FRD: begin
          tgt_q   <= tgt_c;
          state_q <= S_FUPD;
        end
        S_FUPD: begin
          if (out_free) begin
            if (!hit_q) begin
              valid_q[tgt_q] <= 1'b1;
              flag_q[tgt_q]  <= 1'b0;
              ins_seq_q      <= ins_seq_q + 32'd1;
            end
            used_q  <= used_n;
            flags_q <= flags_n;
            out_valid_q <= 1'b1;
            res_q <= '{kind: hit_q ? KIND_UPD : (full ? KIND_EVICT : KIND_NEW),
                       slot: 5'(tgt_q), xmit_addr: ne.addr, frame_count: ne.count,
                       rate_value: ne.bucket, ssn_max_jump: ne.max_jump,
                       chan: ne.channel, bcast_seen: ne.bcast,
                       flood_total: 6'(flags_n), used_entries: 6'(used_n),
                       last_item: 1'b1};
            state_q <= S_IDLE;
          end
        end
        S_DROP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            res_q <= '{kind: KIND_DROP, flood_total: 6'(flags_q),
                       used_entries: 6'(used_q), last_item: 1'b1, default: '0};
            state_q <= S_IDLE;
          end
        end
        S_TSCAN: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q != '0) begin
            if (valid_q[e]) begin
              flag_q[e]   <= now_flag;
              rising_q[e] <= now_flag && !flag_q[e];
            end else begin
              rising_q[e] <= 1'b0;
            end
            fcnt_q <= fcnt_q + CntW'(valid_q[e] && now_flag);
          end
          if (cnt_q == CntW'(Depth)) begin
            flags_q <= fcnt_q + CntW'(valid_q[e] && now_flag);
            cnt_q   <= '0;
            state_q <= S_TCHK;
          end
        end
        S_TCHK: begin
          if (cnt_q == CntW'(Depth)) state_q <= S_TSUM;
          else if (rising_q[cnt_q[IdxW-1:0]]) state_q <= S_TOUT;
          else cnt_q <= cnt_q + CntW'(1);
        end
        S_TOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            res_q <= '{kind: KIND_FLOOD, slot: 5'(cnt_q[IdxW-1:0]),
                       xmit_addr: rdata_q.addr, frame_count: rdata_q.count,
                       rate_value: rdata_q.rate, ssn_max_jump: rdata_q.max_jump,
                       chan: rdata_q.channel, bcast_seen: rdata_q.bcast,
                       flood_total: 6'(flags_q), used_entries: 6'(used_q),
                       last_item: 1'b0};
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= S_TCHK;
          end
        end
        S_TSUM: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            res_q <= '{kind: KIND_SUM, flood_total: 6'(flags_q),
                       used_entries: 6'(used_q), last_item: 1'b1, default: '0};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/per_source_bar_flood_table.sv
// Per-source Block Ack Request flood table.
// Input channel in_valid_i/in_ready_o carries one item: a captured frame
// (func_i = 0) or a one-second tick (func_i = 1). A two-entry queue takes
// items while the table engine works, so in_ready_o drops only when it fills.
// Output channel out_valid_o/out_ready_i carries results from one output
// register; a frame gives one result, a tick gives one flood result per
// newly flagged slot in slot order and then a summary with last_item_o set.
// In the engine a frame takes one 32-entry sweep of the table memory (one
// read a cycle) for lookup and victim choice, one read and one write-back.
// A tick takes a sweep of the table to roll buckets into rates, then a scan
// of the raised flags.
// cfg_we_i writes flood_rate at once; write it only while the block is idle.
// Reset empties the table and the queue and sets flood_rate to 12; no
// clearing pass is needed. A stalled receiver holds the result register and
// the engine waits on it; the queue keeps taking items until full.
module per_source_bar_flood_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic        pkt_is_ctrl_i,
  input  logic [11:0] frame_len_i,
  input  logic [7:0]  frame_ctl0_i,
  input  logic [47:0] recv_addr_i,
  input  logic [47:0] xmit_addr_i,
  input  logic [15:0] seq_ctrl_i,
  input  logic [3:0]  channel_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [4:0]  slot_index_o,
  output logic [47:0] xmit_addr_out_o,
  output logic [23:0] frame_count_o,
  output logic [15:0] rate_value_o,
  output logic [10:0] ssn_max_jump_o,
  output logic [3:0]  chan_out_o,
  output logic        bcast_seen_o,
  output logic [5:0]  flood_total_o,
  output logic [5:0]  used_entries_o,
  output logic        last_item_o
);
  import psbf_pkg::*;

  logic [9:0] flood_rate_q;
  logic       q_valid, q_pop;
  cmd_t       q_data;
  res_t       res;
  status_t    status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) flood_rate_q <= FloodRateRst;
    else if (cfg_we_i) flood_rate_q <= cfg_wdata_i;
  end

  psbf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .pkt_is_ctrl_i,
    .frame_len_i, .frame_ctl0_i, .recv_addr_i, .xmit_addr_i, .seq_ctrl_i,
    .channel_i, .now_ms_i,
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  psbf_back u_back (
    .clk_i, .rst_ni,
    .flood_rate_i (flood_rate_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_valid_o,
    .out_ready_i,
    .res_o        (res),
    .status_o     (status)
  );

  assign result_kind_o   = res.kind;
  assign slot_index_o    = res.slot;
  assign xmit_addr_out_o = res.xmit_addr;
  assign frame_count_o   = res.frame_count;
  assign rate_value_o    = res.rate_value;
  assign ssn_max_jump_o  = res.ssn_max_jump;
  assign chan_out_o      = res.chan;
  assign bcast_seen_o    = res.bcast_seen;
  assign flood_total_o   = res.flood_total;
  assign used_entries_o  = res.used_entries;
  assign last_item_o     = res.last_item;

  a_flags_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.flags <= status.used) else $error("flag count exceeds used count");

  a_used_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.used <= CntW'(Depth)) else $error("used count exceeds depth");

  a_flood_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_FLOOD |-> !last_item_o)
    else $error("flood result marked last");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_SUM || result_kind_o == KIND_DROP)
    |-> last_item_o && slot_index_o == 5'd0)
    else $error("summary or drop result malformed");

endmodule
